[hw/rtl/ros_pkg.sv]
package ros_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [PIX_W-1:0] FRAME_WIDTH_RST  = 16'd320;
    localparam logic [PIX_W-1:0] FRAME_HEIGHT_RST = 16'd240;

    localparam logic [COUNT_W-1:0] COUNT_SATURATE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] width;
        logic [PIX_W-1:0] height;
        logic [PIX_W-1:0] stroke;
    } clip_t;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] width;
        logic [PIX_W-1:0] height;
        logic [PIX_W-1:0] thick;
        logic [PIX_W-1:0] edge_rows;
        logic [PIX_W-1:0] side_rows;
        logic [PIX_W:0]   dbl;
    } stroke_t;

    typedef struct packed {
        logic               ok;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   width;
        logic [PIX_W-1:0]   height;
        logic [PIX_W-1:0]   thick;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

[hw/rtl/ros_clip.sv]
module ros_clip
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ros_pkg::COORD_W-1:0]   left_in,
    input  logic [ros_pkg::COORD_W-1:0]   top_in,
    input  logic [ros_pkg::COORD_W-1:0]   right_in,
    input  logic [ros_pkg::COORD_W-1:0]   bottom_in,
    input  logic [ros_pkg::PIX_W-1:0]     stroke_in,
    input  logic [ros_pkg::PIX_W-1:0]     frame_width,
    input  logic [ros_pkg::PIX_W-1:0]     frame_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ros_pkg::clip_t                out_data
);
    import ros_pkg::*;

    logic                      v1_reg;
    logic                      v2_reg;
    logic                      adv1;
    logic                      adv2;
    logic                      rej1_reg;
    logic                      rej1_next;
    logic signed [COORD_W-1:0] lx1_reg;
    logic signed [COORD_W-1:0] lx1_next;
    logic signed [COORD_W-1:0] ty1_reg;
    logic signed [COORD_W-1:0] ty1_next;
    logic signed [COORD_W-1:0] rx1_reg;
    logic signed [COORD_W-1:0] rx1_next;
    logic signed [COORD_W-1:0] by1_reg;
    logic signed [COORD_W-1:0] by1_next;
    logic [PIX_W-1:0]          t1_reg;
    logic signed [COORD_W-1:0] fw_s;
    logic signed [COORD_W-1:0] fh_s;
    clip_t                     c2_reg;
    clip_t                     c2_next;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign fw_s = $signed({{(COORD_W-PIX_W){1'b0}}, frame_width});
    assign fh_s = $signed({{(COORD_W-PIX_W){1'b0}}, frame_height});

    // stage 1: clamp corners to the frame, flag a zero frame size or zero stroke for rejection
    always_comb
    begin
        rej1_next = (frame_width == '0) || (frame_height == '0) || (stroke_in == '0);
        lx1_next  = $signed(left_in)  < 0 ? '0 : $signed(left_in);
        ty1_next  = $signed(top_in)   < 0 ? '0 : $signed(top_in);
        rx1_next  = $signed(right_in)  > fw_s ? fw_s : $signed(right_in);
        by1_next  = $signed(bottom_in) > fh_s ? fh_s : $signed(bottom_in);
    end

    // stage 2: emptiness check and size
    always_comb
    begin
        c2_next.ok     = !rej1_reg && (rx1_reg > lx1_reg) && (by1_reg > ty1_reg);
        c2_next.left   = lx1_reg[PIX_W-1:0];
        c2_next.top    = ty1_reg[PIX_W-1:0];
        c2_next.width  = rx1_reg[PIX_W-1:0] - lx1_reg[PIX_W-1:0];
        c2_next.height = by1_reg[PIX_W-1:0] - ty1_reg[PIX_W-1:0];
        c2_next.stroke = t1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            rej1_reg <= rej1_next;
            lx1_reg  <= lx1_next;
            ty1_reg  <= ty1_next;
            rx1_reg  <= rx1_next;
            by1_reg  <= by1_next;
            t1_reg   <= stroke_in;
        end
        if (adv2)
            c2_reg <= c2_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = c2_reg;

endmodule

[hw/rtl/ros_stroke.sv]
module ros_stroke
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ros_pkg::clip_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ros_pkg::stroke_t out_data
);
    import ros_pkg::*;

    logic             v3_reg;
    logic             v4_reg;
    logic             v5_reg;
    logic             adv3;
    logic             adv4;
    logic             adv5;
    clip_t            c3_reg;
    clip_t            c3_next;
    clip_t            c4_reg;
    clip_t            c4_next;
    stroke_t          s5_reg;
    stroke_t          s5_next;
    logic [PIX_W:0]   w_round;
    logic [PIX_W:0]   h_round;
    logic [PIX_W-1:0] t_h;
    logic [PIX_W:0]   dbl;

    assign adv5     = !v5_reg || out_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign in_ready = adv3;

    // stage 3: clamp against half the width
    always_comb
    begin
        w_round = {1'b0, in_data.width} + (PIX_W+1)'(1);
        c3_next = in_data;
        if (in_data.stroke > {1'b0, in_data.width[PIX_W-1:1]})
            c3_next.stroke = w_round[PIX_W:1];
    end

    // stage 4: clamp against half the height, floor of one
    always_comb
    begin
        h_round = {1'b0, c3_reg.height} + (PIX_W+1)'(1);
        t_h     = c3_reg.stroke;
        if (c3_reg.stroke > {1'b0, c3_reg.height[PIX_W-1:1]})
            t_h = h_round[PIX_W:1];
        c4_next        = c3_reg;
        c4_next.stroke = (t_h == '0) ? PIX_W'(1) : t_h;
    end

    // stage 5: band heights
    always_comb
    begin
        dbl               = {c4_reg.stroke, 1'b0};
        s5_next.ok        = c4_reg.ok;
        s5_next.left      = c4_reg.left;
        s5_next.top       = c4_reg.top;
        s5_next.width     = c4_reg.width;
        s5_next.height    = c4_reg.height;
        s5_next.thick     = c4_reg.stroke;
        s5_next.dbl       = dbl;
        s5_next.edge_rows = (dbl > {1'b0, c4_reg.height}) ? c4_reg.height : dbl[PIX_W-1:0];
        s5_next.side_rows = c4_reg.height - s5_next.edge_rows;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
                v3_reg <= in_valid;
            if (adv4)
                v4_reg <= v3_reg;
            if (adv5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
            c3_reg <= c3_next;
        if (adv4)
            c4_reg <= c4_next;
        if (adv5)
            s5_reg <= s5_next;
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

endmodule

[hw/rtl/ros_count.sv]
module ros_count
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ros_pkg::stroke_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ros_pkg::result_t out_data
);
    import ros_pkg::*;

    logic                 v6_reg;
    logic                 v7_reg;
    logic                 adv6;
    logic                 adv7;
    stroke_t              s6_reg;
    logic [COUNT_W-1:0]   pe6_reg;
    logic [COUNT_W:0]     ps6_reg;
    logic [COUNT_W+1:0]   sum;
    result_t              r7_reg;
    result_t              r7_next;

    assign adv7     = !v7_reg || out_ready;
    assign adv6     = !v6_reg || adv7;
    assign in_ready = adv6;

    // stage 7: add bands, saturate, zero a rejected item
    always_comb
    begin
        sum = {2'b00, pe6_reg} + {1'b0, ps6_reg};
        r7_next = '0;
        if (s6_reg.ok)
        begin
            r7_next.ok     = 1'b1;
            r7_next.left   = s6_reg.left;
            r7_next.top    = s6_reg.top;
            r7_next.width  = s6_reg.width;
            r7_next.height = s6_reg.height;
            r7_next.thick  = s6_reg.thick;
            r7_next.count  = (sum[COUNT_W+1:COUNT_W] != 2'b00) ? COUNT_SATURATE
                                                                : sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (adv6)
                v6_reg <= in_valid;
            if (adv7)
                v7_reg <= v6_reg;
        end
    end

    // stage 6: band products
    always_ff @(posedge clk)
    begin
        if (adv6)
        begin
            s6_reg  <= in_data;
            pe6_reg <= COUNT_W'(in_data.edge_rows) * COUNT_W'(in_data.width);
            ps6_reg <= (COUNT_W+1)'(in_data.side_rows) * (COUNT_W+1)'(in_data.dbl);
        end
        if (adv7)
            r7_reg <= r7_next;
    end

    assign out_valid = v7_reg;
    assign out_data  = r7_reg;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg && !r7_reg.ok |-> r7_reg.count == '0 && r7_reg.width == '0
                                 && r7_reg.thick == '0)
        else $error("rejected item carries nonzero fields");
    a_thick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg && r7_reg.ok |-> r7_reg.thick != '0)
        else $error("accepted item with zero thickness");
    a_thick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg && r7_reg.ok |-> r7_reg.thick <= r7_reg.width
                                && r7_reg.thick <= r7_reg.height)
        else $error("thickness exceeds box");
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && adv7 |=> v7_reg)
        else $error("item lost between product and sum stages");
`endif

endmodule

[hw/rtl/rect_outline_setup_core.sv]
// throughput: one item per cycle, every stage holds while the next is full
// stall: back pressure reaches every stage combinationally through the ready chain, bubbles are squeezed out
// reset: rst_n asynchronous active low, clears all valid bits
// reset: frame_width returns to 320 and frame_height to 240
module rect_outline_setup_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // left_in, top_in, right_in, bottom_in, stroke_in
    input  logic [143:0]                    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ok, left_out, top_out, width_out, height_out, thickness_out, store_count, zero pad
    output logic [119:0]                    m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [ros_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ros_pkg::PIX_W-1:0]       cfg_data
);
    import ros_pkg::*;

    logic [PIX_W-1:0] fw_reg;
    logic [PIX_W-1:0] fh_reg;
    logic             clip_valid;
    logic             clip_ready;
    clip_t            clip_data;
    logic             stk_valid;
    logic             stk_ready;
    stroke_t          stk_data;
    result_t          res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    ros_clip u_clip
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .left_in      (s_axis_tdata[31:0]),
        .top_in       (s_axis_tdata[63:32]),
        .right_in     (s_axis_tdata[95:64]),
        .bottom_in    (s_axis_tdata[127:96]),
        .stroke_in    (s_axis_tdata[143:128]),
        .frame_width  (fw_reg),
        .frame_height (fh_reg),
        .out_valid    (clip_valid),
        .out_ready    (clip_ready),
        .out_data     (clip_data)
    );

    ros_stroke u_stroke
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clip_valid),
        .in_ready  (clip_ready),
        .in_data   (clip_data),
        .out_valid (stk_valid),
        .out_ready (stk_ready),
        .out_data  (stk_data)
    );

    ros_count u_count
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stk_valid),
        .in_ready  (stk_ready),
        .in_data   (stk_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_data)
    );

    assign m_axis_tdata = {7'b0, res_data.count, res_data.thick, res_data.height,
                           res_data.width, res_data.top, res_data.left, res_data.ok};

endmodule
